[rtl/core/rvm_pkg.sv]
// ---------------------------------------------------------------------------
// rvm_pkg
// Shared types and constants of the vector-to-vector rotation matrix block.
// ---------------------------------------------------------------------------
package rvm_pkg;

  localparam int FRAC_BITS   = 14;
  localparam int IBITS       = 30;
  localparam int SH          = IBITS - FRAC_BITS;
  localparam int QDEPTH      = 4;
  localparam int QAW         = $clog2(QDEPTH);
  localparam int SQ_STEPS    = 32;
  localparam int NDIV_STEPS  = 31;
  localparam int MDIV_STEPS  = 33;

  localparam longint OUT_HI = (FRAC_BITS >= 15) ? 32767 : (longint'(1) << FRAC_BITS);
  localparam longint OUT_LO = (FRAC_BITS >= 15) ? -32768 : -(longint'(1) << FRAC_BITS);
  localparam logic signed [15:0] ID_ONE = 16'(OUT_HI);

  typedef struct packed {
    logic [2:0][15:0] a;
    logic [2:0][15:0] b;
    logic [31:0]      a2;
    logic [31:0]      b2;
    logic             degen;
  } rvm_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rvm_qstat_t;

endpackage

[rtl/core/rvm_front.sv]
// ---------------------------------------------------------------------------
// rvm_front
// Input register, integer squares and products, zero and opposite check.
// ---------------------------------------------------------------------------
module rvm_front import rvm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [15:0]       src_x,
  input  logic [15:0]       src_y,
  input  logic [15:0]       src_z,
  input  logic [15:0]       dst_x,
  input  logic [15:0]       dst_y,
  input  logic [15:0]       dst_z,
  input  rvm_qstat_t        qstat,
  output logic              push,
  output rvm_item_t         item
);

  logic                   f_valid;
  logic [2:0][15:0]       ra;
  logic [2:0][15:0]       rb;
  logic [2:0][30:0]       aa;
  logic [2:0][30:0]       bb;
  logic [8:0][31:0]       ab;
  logic [2:0][15:0]       av;
  logic [2:0][15:0]       bv;
  logic                   accept;
  logic signed [32:0]     c0, c1, c2;
  logic signed [33:0]     dot;

  assign av = {src_z, src_y, src_x};
  assign bv = {dst_z, dst_y, dst_x};

  assign push     = f_valid && !qstat.full;
  assign in_stall = f_valid && qstat.full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ra <= av;
      rb <= bv;
      for (int i = 0; i < 3; i++) begin
        aa[i] <= 31'($signed(av[i]) * $signed(av[i]));
        bb[i] <= 31'($signed(bv[i]) * $signed(bv[i]));
        for (int j = 0; j < 3; j++) begin
          ab[i*3+j] <= 32'($signed(av[i]) * $signed(bv[j]));
        end
      end
    end
  end

  always_comb begin
    c0  = 33'($signed(ab[5])) - 33'($signed(ab[7]));
    c1  = 33'($signed(ab[6])) - 33'($signed(ab[2]));
    c2  = 33'($signed(ab[1])) - 33'($signed(ab[3]));
    dot = 34'($signed(ab[0])) + 34'($signed(ab[4])) + 34'($signed(ab[8]));
    item.a  = ra;
    item.b  = rb;
    item.a2 = 32'(aa[0]) + 32'(aa[1]) + 32'(aa[2]);
    item.b2 = 32'(bb[0]) + 32'(bb[1]) + 32'(bb[2]);
    item.degen = (item.a2 == 32'd0) || (item.b2 == 32'd0) ||
                 (c0 == 33'sd0 && c1 == 33'sd0 && c2 == 33'sd0 && dot < 34'sd0);
  end

endmodule

[rtl/core/rvm_queue.sv]
// ---------------------------------------------------------------------------
// rvm_queue
// Small queue between the classifying front and the arithmetic back.
// ---------------------------------------------------------------------------
module rvm_queue import rvm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  rvm_item_t  item_in,
  input  logic       pop,
  output rvm_item_t  item_out,
  output rvm_qstat_t qstat
);

  rvm_item_t        mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     count;

  assign qstat.full  = (count == (QAW+1)'(QDEPTH));
  assign qstat.empty = (count == '0);
  assign item_out    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      if (push && !pop) begin
        count <= count + (QAW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QAW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_in;
    end
  end

endmodule

[rtl/core/rvm_back.sv]
// ---------------------------------------------------------------------------
// rvm_back
// Pipelined normalize, cross and dot product, matrix terms and output stage.
// ---------------------------------------------------------------------------
module rvm_back import rvm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  rvm_qstat_t        qstat,
  input  rvm_item_t         item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [8:0][15:0]  m,
  output logic              degenerate
);

  localparam int NST = 2 + SQ_STEPS + 1 + NDIV_STEPS + 3 + 1 + MDIV_STEPS;

  typedef struct packed {
    logic [5:0][15:0] mag;
    logic [5:0]       neg;
    logic [4:0]       ka;
    logic [4:0]       kb;
    logic             degen;
  } side_t;

  typedef struct packed {
    logic [1:0][61:0] t;
    logic [1:0][62:0] res;
    side_t            sd;
  } sq_t;

  typedef struct packed {
    logic [5:0][61:0] rem;
    logic [5:0][30:0] q;
    logic [1:0][30:0] s;
    logic [5:0]       neg;
    logic             degen;
  } nd_t;

  typedef struct packed {
    logic [8:0][63:0] p;
    logic             degen;
  } pr_t;

  typedef struct packed {
    logic [2:0][32:0] v;
    logic [32:0]      e;
    logic [31:0]      den;
    logic             degen;
  } ev_t;

  typedef struct packed {
    logic [5:0][65:0] vv;
    logic [2:0][32:0] v;
    logic [32:0]      e;
    logic [31:0]      den;
    logic             degen;
  } vv_t;

  typedef struct packed {
    logic [5:0][62:0] rem;
    logic [5:0][32:0] q;
    logic [5:0]       sat;
    logic [5:0]       neg;
    logic [2:0][32:0] v;
    logic [32:0]      e;
    logic [31:0]      den;
    logic             degen;
  } md_t;

  logic            en;
  logic [NST-1:0]  vld;
  rvm_item_t       r0;
  sq_t             sq [SQ_STEPS+1];
  nd_t             nd [NDIV_STEPS+1];
  pr_t             pr;
  ev_t             ev;
  vv_t             vvr;
  md_t             md [MDIV_STEPS+1];

  function automatic logic [4:0] msb_pos(input logic [31:0] x);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) p = 5'(i);
    end
    return p;
  endfunction

  function automatic logic [4:0] norm_k(input logic [31:0] x);
    logic [6:0] d;
    d = 7'd61 - 7'(msb_pos(x));
    return 5'(d >> 1);
  endfunction

  function automatic sq_t sq_step(input sq_t x, input int j);
    logic [62:0] bitv;
    logic [62:0] sum;
    sq_t         y;
    y    = x;
    bitv = 63'(1) << (62 - 2*j);
    for (int w = 0; w < 2; w++) begin
      sum = x.res[w] + bitv;
      if ({1'b0, x.t[w]} >= sum) begin
        y.t[w]   = 62'({1'b0, x.t[w]} - sum);
        y.res[w] = (x.res[w] >> 1) + bitv;
      end else begin
        y.res[w] = x.res[w] >> 1;
      end
    end
    return y;
  endfunction

  function automatic nd_t nd_step(input nd_t x, input int j);
    logic [61:0] dsh;
    nd_t         y;
    y = x;
    for (int c = 0; c < 6; c++) begin
      dsh = 62'(x.s[(c >= 3) ? 1 : 0]) << (NDIV_STEPS - 1 - j);
      if (x.rem[c] >= dsh) begin
        y.rem[c] = x.rem[c] - dsh;
        y.q[c][NDIV_STEPS - 1 - j] = 1'b1;
      end
    end
    return y;
  endfunction

  function automatic md_t md_step(input md_t x, input int j);
    logic [64:0] dsh;
    md_t         y;
    y   = x;
    dsh = 65'(x.den) << (MDIV_STEPS - 1 - j);
    for (int c = 0; c < 6; c++) begin
      if (65'(x.rem[c]) >= dsh) begin
        y.rem[c] = 63'(65'(x.rem[c]) - dsh);
        y.q[c][MDIV_STEPS - 1 - j] = 1'b1;
      end
    end
    return y;
  endfunction

  function automatic logic signed [32:0] rnd30(input logic signed [65:0] x);
    logic [65:0] mag;
    logic [65:0] r;
    mag = x[65] ? 66'(-x) : 66'(x);
    r   = (mag + (66'(1) << (IBITS - 1))) >> IBITS;
    return x[65] ? -$signed(33'(r)) : $signed(33'(r));
  endfunction

  function automatic logic signed [15:0] to_out(input logic signed [39:0] x);
    localparam longint RND = (SH > 0) ? (longint'(1) << (SH - 1)) : 0;
    logic [39:0]        mag;
    logic [39:0]        r;
    logic signed [40:0] v;
    mag = x[39] ? 40'(-x) : 40'(x);
    r   = (mag + 40'(RND)) >> SH;
    v   = x[39] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    if (v > $signed(41'(OUT_HI))) v = $signed(41'(OUT_HI));
    if (v < $signed(41'(OUT_LO))) v = $signed(41'(OUT_LO));
    return 16'(v);
  endfunction

  function automatic logic signed [39:0] qval(input logic [32:0] q, input logic sat,
                                              input logic neg);
    logic [33:0] qm;
    qm = sat ? (34'(1) << 33) : {1'b0, q};
    return neg ? -$signed(40'(qm)) : $signed(40'(qm));
  endfunction

  function automatic logic signed [39:0] sx40(input logic [32:0] x);
    return 40'($signed(x));
  endfunction

  assign en  = !(out_valid && out_stall);
  assign pop = en && !qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[NST-2:0], !qstat.empty};
      out_valid <= vld[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    logic signed [16:0] ai;
    logic [4:0]         kk;
    logic signed [31:0] fa [3];
    logic signed [31:0] fb [3];
    logic signed [33:0] den;
    logic signed [32:0] ev_e;
    logic [65:0]        mg;
    logic [62:0]        np;
    logic signed [39:0] qq [6];
    logic [1:0][1:0]    pi;
    if (en) begin
      r0 <= item;

      sq[0].t[0] <= 62'(r0.a2) << {norm_k(r0.a2), 1'b0};
      sq[0].t[1] <= 62'(r0.b2) << {norm_k(r0.b2), 1'b0};
      sq[0].res  <= '0;
      for (int c = 0; c < 6; c++) begin
        ai = (c < 3) ? 17'($signed(r0.a[c % 3])) : 17'($signed(r0.b[c % 3]));
        sq[0].sd.mag[c] <= 16'(ai < 0 ? -ai : ai);
        sq[0].sd.neg[c] <= ai[16];
      end
      sq[0].sd.ka    <= norm_k(r0.a2);
      sq[0].sd.kb    <= norm_k(r0.b2);
      sq[0].sd.degen <= r0.degen;

      for (int j = 0; j < SQ_STEPS; j++) begin
        sq[j+1] <= sq_step(sq[j], j);
      end

      for (int c = 0; c < 6; c++) begin
        kk = (c < 3) ? sq[SQ_STEPS].sd.ka : sq[SQ_STEPS].sd.kb;
        nd[0].rem[c] <= ((62'(sq[SQ_STEPS].sd.mag[c]) << kk) << IBITS) +
                        62'(sq[SQ_STEPS].res[(c < 3) ? 0 : 1][30:1]);
      end
      nd[0].q     <= '0;
      nd[0].s[0]  <= sq[SQ_STEPS].res[0][30:0];
      nd[0].s[1]  <= sq[SQ_STEPS].res[1][30:0];
      nd[0].neg   <= sq[SQ_STEPS].sd.neg;
      nd[0].degen <= sq[SQ_STEPS].sd.degen;

      for (int j = 0; j < NDIV_STEPS; j++) begin
        nd[j+1] <= nd_step(nd[j], j);
      end

      for (int i = 0; i < 3; i++) begin
        fa[i] = nd[NDIV_STEPS].neg[i] ? -$signed(32'(nd[NDIV_STEPS].q[i]))
                                      : $signed(32'(nd[NDIV_STEPS].q[i]));
        fb[i] = nd[NDIV_STEPS].neg[i+3] ? -$signed(32'(nd[NDIV_STEPS].q[i+3]))
                                        : $signed(32'(nd[NDIV_STEPS].q[i+3]));
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pr.p[i*3+j] <= 64'(fa[i] * fb[j]);
        end
      end
      pr.degen <= nd[NDIV_STEPS].degen;

      ev_e = rnd30(66'($signed(pr.p[0])) + 66'($signed(pr.p[4])) +
                   66'($signed(pr.p[8])));
      den  = (34'sd1 <<< IBITS) + 34'(ev_e);
      ev.v[0] <= rnd30(66'($signed(pr.p[5])) - 66'($signed(pr.p[7])));
      ev.v[1] <= rnd30(66'($signed(pr.p[6])) - 66'($signed(pr.p[2])));
      ev.v[2] <= rnd30(66'($signed(pr.p[1])) - 66'($signed(pr.p[3])));
      ev.e     <= ev_e;
      ev.den   <= den[31:0];
      ev.degen <= pr.degen || den[33] || (den == 34'sd0);

      pi = {2'd0, 2'd0};
      for (int c = 0; c < 6; c++) begin
        case (c)
          0:       pi = {2'd0, 2'd0};
          1:       pi = {2'd0, 2'd1};
          2:       pi = {2'd0, 2'd2};
          3:       pi = {2'd1, 2'd1};
          4:       pi = {2'd1, 2'd2};
          default: pi = {2'd2, 2'd2};
        endcase
        vvr.vv[c] <= 66'($signed(ev.v[pi[1]]) * $signed(ev.v[pi[0]]));
      end
      vvr.v     <= ev.v;
      vvr.e     <= ev.e;
      vvr.den   <= ev.den;
      vvr.degen <= ev.degen;

      for (int c = 0; c < 6; c++) begin
        mg = vvr.vv[c][65] ? 66'(-$signed(vvr.vv[c])) : vvr.vv[c];
        np = 63'(mg) + 63'(vvr.den >> 1);
        md[0].rem[c] <= np;
        md[0].neg[c] <= vvr.vv[c][65];
        md[0].sat[c] <= {3'b000, np} >= {1'b0, vvr.den, 33'd0};
      end
      md[0].q     <= '0;
      md[0].v     <= vvr.v;
      md[0].e     <= vvr.e;
      md[0].den   <= vvr.den;
      md[0].degen <= vvr.degen;

      for (int j = 0; j < MDIV_STEPS; j++) begin
        md[j+1] <= md_step(md[j], j);
      end

      for (int c = 0; c < 6; c++) begin
        qq[c] = qval(md[MDIV_STEPS].q[c], md[MDIV_STEPS].sat[c], md[MDIV_STEPS].neg[c]);
      end
      if (md[MDIV_STEPS].degen) begin
        m <= {ID_ONE, 16'd0, 16'd0, 16'd0, ID_ONE, 16'd0, 16'd0, 16'd0, ID_ONE};
      end else begin
        m[0] <= to_out(qq[0] + sx40(md[MDIV_STEPS].e));
        m[1] <= to_out(qq[1] - sx40(md[MDIV_STEPS].v[2]));
        m[2] <= to_out(qq[2] + sx40(md[MDIV_STEPS].v[1]));
        m[3] <= to_out(qq[1] + sx40(md[MDIV_STEPS].v[2]));
        m[4] <= to_out(qq[3] + sx40(md[MDIV_STEPS].e));
        m[5] <= to_out(qq[4] - sx40(md[MDIV_STEPS].v[0]));
        m[6] <= to_out(qq[2] - sx40(md[MDIV_STEPS].v[1]));
        m[7] <= to_out(qq[4] + sx40(md[MDIV_STEPS].v[0]));
        m[8] <= to_out(qq[5] + sx40(md[MDIV_STEPS].e));
      end
      degenerate <= md[MDIV_STEPS].degen;
    end
  end

endmodule

[rtl/core/vector_to_vector_rotation_matrix_top.sv]
// ---------------------------------------------------------------------------
// vector_to_vector_rotation_matrix_top
// Rotation matrix turning a source direction onto a destination direction.
//
//   channel | handshake          | payload
//   --------+--------------------+--------------------------------------
//   in      | in_valid, in_stall | src_x src_y src_z dst_x dst_y dst_z
//   out     | out_valid,out_stall| m00 .. m22, degenerate
//
// one transaction per cycle sustained while the output is not stalled; latency is set by
// the bit-per-stage square root and the two restoring divider pipelines
// synchronous active-high reset clears the valid line and the queue
// an output stall freezes the arithmetic pipeline; the front and a
// four-entry queue keep taking transactions until the queue fills
// ---------------------------------------------------------------------------
module vector_to_vector_rotation_matrix_top import rvm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] src_x,
  input  logic [15:0] src_y,
  input  logic [15:0] src_z,
  input  logic [15:0] dst_x,
  input  logic [15:0] dst_y,
  input  logic [15:0] dst_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] m00,
  output logic [15:0] m01,
  output logic [15:0] m02,
  output logic [15:0] m10,
  output logic [15:0] m11,
  output logic [15:0] m12,
  output logic [15:0] m20,
  output logic [15:0] m21,
  output logic [15:0] m22,
  output logic        degenerate
);

  rvm_qstat_t      qstat;
  rvm_item_t       f_item;
  rvm_item_t       q_item;
  logic            push;
  logic            pop;
  logic [8:0][15:0] m;

  rvm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .src_x    (src_x),
    .src_y    (src_y),
    .src_z    (src_z),
    .dst_x    (dst_x),
    .dst_y    (dst_y),
    .dst_z    (dst_z),
    .qstat    (qstat),
    .push     (push),
    .item     (f_item)
  );

  rvm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item_in  (f_item),
    .pop      (pop),
    .item_out (q_item),
    .qstat    (qstat)
  );

  rvm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .qstat      (qstat),
    .item       (q_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .m          (m),
    .degenerate (degenerate)
  );

  assign m00 = m[0];
  assign m01 = m[1];
  assign m02 = m[2];
  assign m10 = m[3];
  assign m11 = m[4];
  assign m12 = m[5];
  assign m20 = m[6];
  assign m21 = m[7];
  assign m22 = m[8];

endmodule

[rtl/core/rvm_checker.sv]
// ---------------------------------------------------------------------------
// rvm_checker
// Port-level checks of the rotation matrix block, bound to the top level.
// ---------------------------------------------------------------------------
module rvm_checker import rvm_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] m00,
  input logic [15:0] m01,
  input logic [15:0] m02,
  input logic [15:0] m10,
  input logic [15:0] m11,
  input logic [15:0] m12,
  input logic [15:0] m20,
  input logic [15:0] m21,
  input logic [15:0] m22,
  input logic        degenerate
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("out transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(m00) && $stable(m12) && $stable(degenerate))
    else $error("stalled out payload changed");

  a_identity: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> m00 == ID_ONE && m11 == ID_ONE && m22 == ID_ONE &&
      m01 == 16'd0 && m02 == 16'd0 && m10 == 16'd0 && m12 == 16'd0 && m20 == 16'd0)
    else $error("degenerate result is not the identity");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $signed(m00) <= OUT_HI && $signed(m00) >= OUT_LO &&
      $signed(m21) <= OUT_HI && $signed(m21) >= OUT_LO)
    else $error("matrix entry out of range");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out valid after reset");

endmodule

bind vector_to_vector_rotation_matrix_top rvm_checker u_rvm_checker (.*);
